### rtl/frustum_box_sphere_cull_assert.svh
// assertion macros used by the checker file
`ifndef FRUSTUM_BOX_SPHERE_CULL_ASSERT_SVH
`define FRUSTUM_BOX_SPHERE_CULL_ASSERT_SVH

// checked only while out of reset
`define FBSC_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
	else $error(msg);

// checked on every edge, reset included
`define FBSC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/fbsc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package fbsc_pkg;

	localparam int COORD_W    = 16;
	localparam int RADIUS_W   = 15;
	localparam int QSHIFT     = 14;
	localparam int PROD_W     = 2 * COORD_W;
	localparam int DIST_W     = PROD_W + 1;
	localparam int DIST_OUT_W = 32;
	localparam int PLANE_W    = 4 * COORD_W;
	localparam int REGION_W   = 3 * COORD_W;
	localparam int N_PLANE    = 5;
	localparam int PLANE_FAR  = 4;
	localparam int CFG_IDX_W  = 3;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_PLANE_LEFT   = 3'd0,
		CFG_PLANE_RIGHT  = 3'd1,
		CFG_PLANE_TOP    = 3'd2,
		CFG_PLANE_BOTTOM = 3'd3,
		CFG_PLANE_FAR    = 3'd4,
		CFG_REGION_LOW   = 3'd5,
		CFG_REGION_HIGH  = 3'd6
	} cfg_idx_t;

	// x in the low bits, matching the register packing
	typedef struct packed {
		logic signed [COORD_W-1:0] z;
		logic signed [COORD_W-1:0] y;
		logic signed [COORD_W-1:0] x;
	} pt_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] d;
		logic signed [COORD_W-1:0] c;
		logic signed [COORD_W-1:0] b;
		logic signed [COORD_W-1:0] a;
	} plane_t;

	typedef logic signed [DIST_W-1:0] dist_t;

	typedef struct packed {
		logic                kind;
		logic                overlap;
		logic [RADIUS_W-1:0] radius;
	} ctl_t;

	typedef struct packed {
		logic                      kind;
		logic signed [COORD_W-1:0] lo_x;
		logic signed [COORD_W-1:0] lo_y;
		logic signed [COORD_W-1:0] lo_z;
		logic signed [COORD_W-1:0] hi_x;
		logic signed [COORD_W-1:0] hi_y;
		logic signed [COORD_W-1:0] hi_z;
		logic [RADIUS_W-1:0]       radius;
	} item_t;

	typedef struct packed {
		logic                         visible;
		logic signed [DIST_OUT_W-1:0] nearest_distance;
	} result_t;

endpackage

`default_nettype wire

### rtl/fbsc_corner.sv
`timescale 1ns / 1ps
`default_nettype none

module fbsc_corner (
	input  wire                  clk,
	input  wire                  en,
	input  fbsc_pkg::item_t      item,
	input  fbsc_pkg::plane_t     planes [fbsc_pkg::N_PLANE],
	input  fbsc_pkg::pt_t        region_low,
	input  fbsc_pkg::pt_t        region_high,
	output fbsc_pkg::pt_t        far_s1 [fbsc_pkg::N_PLANE],
	output fbsc_pkg::pt_t        near_s1,
	output fbsc_pkg::ctl_t       ctl_s1
);
	import fbsc_pkg::*;

	pt_t  lo;
	pt_t  hi;
	logic overlap;

	// sign bit of the normal component picks the bound; zero counts as positive
	function automatic pt_t pick(input plane_t pl, input pt_t l, input pt_t h,
			input logic far_side);
		pt_t r;
		r.x = (pl.a[COORD_W-1] ^ far_side) ? h.x : l.x;
		r.y = (pl.b[COORD_W-1] ^ far_side) ? h.y : l.y;
		r.z = (pl.c[COORD_W-1] ^ far_side) ? h.z : l.z;
		return r;
	endfunction

	function automatic logic axis_ok(input logic signed [COORD_W-1:0] l,
			input logic signed [COORD_W-1:0] h,
			input logic signed [COORD_W-1:0] rl,
			input logic signed [COORD_W-1:0] rh);
		return (l <= h) && (l <= rh) && (rl <= h) && (rl <= rh);
	endfunction

	always_comb begin
		lo.x = item.lo_x;
		lo.y = item.lo_y;
		lo.z = item.lo_z;
		hi.x = item.hi_x;
		hi.y = item.hi_y;
		hi.z = item.hi_z;
		overlap = axis_ok(lo.x, hi.x, region_low.x, region_high.x)
			&& axis_ok(lo.y, hi.y, region_low.y, region_high.y)
			&& axis_ok(lo.z, hi.z, region_low.z, region_high.z);
	end

	// a sphere uses its centre for every plane
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < N_PLANE; i++) begin
				far_s1[i] <= item.kind ? lo : pick(planes[i], lo, hi, 1'b1);
			end
			near_s1        <= item.kind ? lo : pick(planes[PLANE_FAR], lo, hi, 1'b0);
			ctl_s1.kind    <= item.kind;
			ctl_s1.overlap <= overlap;
			ctl_s1.radius  <= item.radius;
		end
	end

endmodule

`default_nettype wire

### rtl/fbsc_dot.sv
`timescale 1ns / 1ps
`default_nettype none

module fbsc_dot (
	input  wire               clk,
	input  wire               en,
	input  fbsc_pkg::plane_t  plane,
	input  fbsc_pkg::pt_t     pt,
	output fbsc_pkg::dist_t   dist_s3
);
	import fbsc_pkg::*;

	logic signed [PROD_W-1:0] prod_s2 [3];
	dist_t                    dterm;

	// d is Q8.8, lifted to the Q.22 scale of the products
	assign dterm = $signed({{(DIST_W-COORD_W-QSHIFT){plane.d[COORD_W-1]}}, plane.d,
		{QSHIFT{1'b0}}});

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s2[0] <= plane.a * pt.x;
			prod_s2[1] <= plane.b * pt.y;
			prod_s2[2] <= plane.c * pt.z;
			dist_s3    <= DIST_W'(prod_s2[0]) + DIST_W'(prod_s2[1])
				+ DIST_W'(prod_s2[2]) + dterm;
		end
	end

endmodule

`default_nettype wire

### rtl/fbsc_decide.sv
`timescale 1ns / 1ps
`default_nettype none

module fbsc_decide (
	input  wire                clk,
	input  wire                en,
	input  fbsc_pkg::dist_t    far_dist [fbsc_pkg::N_PLANE],
	input  fbsc_pkg::dist_t    near_dist,
	input  fbsc_pkg::ctl_t     ctl,
	output fbsc_pkg::result_t  result_s4
);
	import fbsc_pkg::*;

	localparam int MARGIN_W = DIST_W + 1;
	localparam int NEAR_W   = DIST_W - QSHIFT;

	logic [MARGIN_W-1:0]        rterm;
	logic [MARGIN_W-1:0]        margin [N_PLANE];
	logic                       all_in;
	logic                       visible;
	logic signed [NEAR_W-1:0]   near_q;
	logic [DIST_OUT_W-1:0]      rsub;
	logic [DIST_OUT_W-1:0]      nearest;

	always_comb begin
		// box planes compare against zero, sphere planes against minus the radius
		rterm = ctl.kind ? MARGIN_W'({ctl.radius, {QSHIFT{1'b0}}}) : '0;
		all_in = 1'b1;
		for (int i = 0; i < N_PLANE; i++) begin
			margin[i] = MARGIN_W'(far_dist[i]) + rterm;
			if (margin[i][MARGIN_W-1]) begin
				all_in = 1'b0;
			end
		end
		visible = all_in && (ctl.kind || ctl.overlap);
		// floor to Q8.8; the radius is already Q8.8 so it comes off afterwards
		near_q  = near_dist[DIST_W-1:QSHIFT];
		rsub    = ctl.kind ? DIST_OUT_W'(ctl.radius) : '0;
		nearest = DIST_OUT_W'(near_q) - rsub;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			result_s4.visible          <= visible;
			result_s4.nearest_distance <= visible ? $signed(nearest) : '0;
		end
	end

endmodule

`default_nettype wire

### rtl/frustum_box_sphere_cull.sv
`timescale 1ns / 1ps
`default_nettype none

// Culls one box or sphere per clock against the frustum in the registers.
// Four pipeline stages: corner selection and region-box test, the eighteen
// 16x16 products, the plane sums, then the visibility decision and the
// Q8.8 nearest distance, registered in that order; one item can be taken every
// cycle. A stall on the result side freezes the whole pipe and shows up on
// item_stall in the same cycle.
// cfg_ready is always high; write the registers only while no item is in
// flight.
module frustum_box_sphere_cull (
	input  wire                                 clk,
	input  wire                                 arst_n,
	input  wire                                 item_valid,
	output logic                                item_stall,
	input  fbsc_pkg::item_t                     item,
	output logic                                result_valid,
	input  wire                                 result_stall,
	output fbsc_pkg::result_t                   result,
	input  wire                                 cfg_valid,
	output logic                                cfg_ready,
	input  wire  [fbsc_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire  [fbsc_pkg::PLANE_W-1:0]        cfg_data
);
	import fbsc_pkg::*;

	plane_t  plane_q [N_PLANE];
	pt_t     region_low_q;
	pt_t     region_high_q;

	logic    adv;
	logic    cfg_we;
	logic    v_s1, v_s2, v_s3;

	pt_t     far_s1 [N_PLANE];
	pt_t     near_s1;
	ctl_t    ctl_s1, ctl_s2, ctl_s3;
	dist_t   far_dist_s3 [N_PLANE];
	dist_t   near_dist_s3;

	assign cfg_ready  = 1'b1;
	assign cfg_we     = cfg_valid && cfg_ready;
	assign adv        = !result_valid || !result_stall;
	assign item_stall = !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < N_PLANE; i++) begin
				plane_q[i] <= '0;
			end
			region_low_q  <= '0;
			region_high_q <= '0;
		end else if (cfg_we) begin
			for (int i = 0; i < N_PLANE; i++) begin
				if (cfg_index == CFG_IDX_W'(i)) begin
					plane_q[i] <= cfg_data;
				end
			end
			unique case (cfg_index)
				CFG_REGION_LOW:  region_low_q  <= cfg_data[REGION_W-1:0];
				CFG_REGION_HIGH: region_high_q <= cfg_data[REGION_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1         <= 1'b0;
			v_s2         <= 1'b0;
			v_s3         <= 1'b0;
			result_valid <= 1'b0;
		end else if (adv) begin
			v_s1         <= item_valid;
			v_s2         <= v_s1;
			v_s3         <= v_s2;
			result_valid <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ctl_s2 <= ctl_s1;
			ctl_s3 <= ctl_s2;
		end
	end

	fbsc_corner u_corner (
		.clk         (clk),
		.en          (adv),
		.item        (item),
		.planes      (plane_q),
		.region_low  (region_low_q),
		.region_high (region_high_q),
		.far_s1      (far_s1),
		.near_s1     (near_s1),
		.ctl_s1      (ctl_s1)
	);

	for (genvar g = 0; g < N_PLANE; g++) begin : g_far
		fbsc_dot u_dot (
			.clk     (clk),
			.en      (adv),
			.plane   (plane_q[g]),
			.pt      (far_s1[g]),
			.dist_s3 (far_dist_s3[g])
		);
	end

	fbsc_dot u_dot_near (
		.clk     (clk),
		.en      (adv),
		.plane   (plane_q[PLANE_FAR]),
		.pt      (near_s1),
		.dist_s3 (near_dist_s3)
	);

	fbsc_decide u_decide (
		.clk       (clk),
		.en        (adv),
		.far_dist  (far_dist_s3),
		.near_dist (near_dist_s3),
		.ctl       (ctl_s3),
		.result_s4 (result)
	);

endmodule

`default_nettype wire

### rtl/fbsc_checker.sv
`timescale 1ns / 1ps
`default_nettype none

`include "frustum_box_sphere_cull_assert.svh"

module fbsc_checker (
	input wire                clk,
	input wire                arst_n,
	input wire                item_valid,
	input wire                item_stall,
	input wire                result_valid,
	input wire                result_stall,
	input fbsc_pkg::result_t  result
);

	// a culled volume never carries a distance
	`FBSC_ASSERT(a_culled_zero, clk, arst_n, result_valid && !result.visible |-> result.nearest_distance == '0, "culled result with nonzero distance")

	// input side only backs up when the result side is blocked
	`FBSC_ASSERT(a_stall_cause, clk, arst_n, item_stall |-> result_valid && result_stall, "input stalled without output stall")

	`FBSC_ASSERT(a_result_hold, clk, arst_n, result_valid && result_stall |=> result_valid && $stable(result), "stalled result changed")

	// reset has cleared the output by the edge after it is seen low
	`FBSC_ASSERT_ALWAYS(a_reset_empty, clk, !arst_n |=> !result_valid, "result valid during reset")

	// an offered item with free output is never refused
	`FBSC_ASSERT(a_no_refuse, clk, arst_n, item_valid && !result_valid |-> !item_stall, "item refused with empty output")

endmodule

bind frustum_box_sphere_cull fbsc_checker u_fbsc_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.item_valid   (item_valid),
	.item_stall   (item_stall),
	.result_valid (result_valid),
	.result_stall (result_stall),
	.result       (result)
);

`default_nettype wire

### tb/sv/frustum_box_sphere_cull_tb.sv
`timescale 1ns / 1ps

module frustum_box_sphere_cull_tb;
	import fbsc_pkg::*;

	localparam logic KIND_BOX    = 1'b0;
	localparam logic KIND_SPHERE = 1'b1;

	// frustum settings used by the directed table
	localparam int SET_RESET    = 0;
	localparam int SET_CUBE     = 1;
	localparam int SET_INVERTED = 2;
	localparam int SET_EXTREME  = 3;

	localparam int RANDOM_PHASES = 6;
	localparam int PHASE_ITEMS   = 85;
	localparam int CYCLE_LIMIT   = 200000;

	typedef struct packed {
		logic [PLANE_W-1:0]  left;
		logic [PLANE_W-1:0]  right;
		logic [PLANE_W-1:0]  top;
		logic [PLANE_W-1:0]  bottom;
		logic [PLANE_W-1:0]  far_plane;
		logic [REGION_W-1:0] region_lo;
		logic [REGION_W-1:0] region_hi;
	} frustum_t;

	typedef struct {
		int      setting;
		item_t   it;
		bit      known;
		result_t want;
	} row_t;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      item_valid = 1'b0;
	logic      item_stall;
	item_t     item = '0;
	logic      result_valid;
	logic      result_stall = 1'b0;
	result_t   result;
	logic      cfg_valid = 1'b0;
	logic      cfg_ready;
	cfg_idx_t  cfg_index = CFG_PLANE_LEFT;
	logic [PLANE_W-1:0] cfg_data = '0;

	frustum_t  view = '0;
	result_t   awaited_culls[$];
	row_t      plan[$];
	bit        calm = 1'b0;
	int        fails = 0;
	int        cycles = 0;

	frustum_box_sphere_cull u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always #5 clk = ~clk;

	// ---------------------------------------------------------------- predictor

	function automatic longint lane(logic [PLANE_W-1:0] w, int k);
		logic signed [COORD_W-1:0] v;
		v = w[COORD_W*k +: COORD_W];
		return longint'(v);
	endfunction

	// exact distance, Q1.14 times Q8.8
	function automatic longint plane_dist(logic [PLANE_W-1:0] pl, longint x, longint y,
			longint z);
		return lane(pl, 0) * x + lane(pl, 1) * y + lane(pl, 2) * z
			+ (lane(pl, 3) <<< QSHIFT);
	endfunction

	// corner farthest along the normal, or nearest; zero component counts as positive
	function automatic longint corner_dist(logic [PLANE_W-1:0] pl, item_t it, bit far_side);
		longint x, y, z;
		x = ((lane(pl, 0) >= 0) == far_side) ? longint'(it.hi_x) : longint'(it.lo_x);
		y = ((lane(pl, 1) >= 0) == far_side) ? longint'(it.hi_y) : longint'(it.lo_y);
		z = ((lane(pl, 2) >= 0) == far_side) ? longint'(it.hi_z) : longint'(it.lo_z);
		return plane_dist(pl, x, y, z);
	endfunction

	function automatic logic signed [DIST_OUT_W-1:0] to_q88(longint v);
		longint q;
		q = v >>> QSHIFT;
		if (q > 64'sd2147483647)
			q = 64'sd2147483647;
		if (q < -64'sd2147483648)
			q = -64'sd2147483648;
		return q[DIST_OUT_W-1:0];
	endfunction

	function automatic result_t cull_predict(item_t it);
		result_t r;
		bit      vis;
		longint  lo[3], hi[3], a, b, negr, d;
		vis = 1'b1;
		r = '0;
		if (it.kind == KIND_BOX) begin
			lo[0] = it.lo_x; lo[1] = it.lo_y; lo[2] = it.lo_z;
			hi[0] = it.hi_x; hi[1] = it.hi_y; hi[2] = it.hi_z;
			for (int k = 0; k < 3; k++) begin
				a = lane({16'h0, view.region_lo}, k);
				b = lane({16'h0, view.region_hi}, k);
				if (lo[k] > a)
					a = lo[k];
				if (hi[k] < b)
					b = hi[k];
				if (a > b)
					vis = 1'b0;
			end
			if (vis && (corner_dist(view.left, it, 1'b1) < 0
					|| corner_dist(view.right, it, 1'b1) < 0
					|| corner_dist(view.top, it, 1'b1) < 0
					|| corner_dist(view.bottom, it, 1'b1) < 0
					|| corner_dist(view.far_plane, it, 1'b1) < 0))
				vis = 1'b0;
			if (vis)
				r.nearest_distance = to_q88(corner_dist(view.far_plane, it, 1'b0));
		end else begin
			negr = -(longint'(it.radius) <<< QSHIFT);
			a = it.lo_x; b = it.lo_y; d = it.lo_z;
			if (plane_dist(view.left, a, b, d) < negr
					|| plane_dist(view.right, a, b, d) < negr
					|| plane_dist(view.top, a, b, d) < negr
					|| plane_dist(view.bottom, a, b, d) < negr)
				vis = 1'b0;
			d = plane_dist(view.far_plane, a, b, d);
			if (vis && d < negr)
				vis = 1'b0;
			if (vis)
				r.nearest_distance = to_q88(d + negr);
		end
		r.visible = vis;
		return r;
	endfunction

	// ---------------------------------------------------------------- stimulus helpers

	function automatic logic [PLANE_W-1:0] plane(int a, int b, int c, int d);
		return {16'(d), 16'(c), 16'(b), 16'(a)};
	endfunction

	function automatic logic [REGION_W-1:0] region(int x, int y, int z);
		return {16'(z), 16'(y), 16'(x)};
	endfunction

	function automatic logic signed [COORD_W-1:0] jitter(int span);
		int v;
		v = $urandom_range(0, 2 * span);
		v -= span;
		return 16'(v);
	endfunction

	function automatic logic [COORD_W-1:0] rim();
		case ($urandom_range(3))
			0: return 16'h8000;
			1: return 16'h7fff;
			2: return 16'h0000;
			default: return 16'hffff;
		endcase
	endfunction

	function automatic row_t box_row(int s, int lx, int ly, int lz, int hx, int hy, int hz,
			bit known = 1'b0, bit vis = 1'b0, int want_dist = 0);
		row_t r;
		r.setting = s;
		r.it = '0;
		r.it.kind = KIND_BOX;
		r.it.lo_x = 16'(lx); r.it.lo_y = 16'(ly); r.it.lo_z = 16'(lz);
		r.it.hi_x = 16'(hx); r.it.hi_y = 16'(hy); r.it.hi_z = 16'(hz);
		r.known = known;
		r.want.visible = vis;
		r.want.nearest_distance = 32'(want_dist);
		return r;
	endfunction

	function automatic row_t ball_row(int s, int x, int y, int z, int rad,
			bit known = 1'b0, bit vis = 1'b0, int want_dist = 0);
		row_t r;
		r.setting = s;
		r.it = '0;
		r.it.kind = KIND_SPHERE;
		r.it.lo_x = 16'(x); r.it.lo_y = 16'(y); r.it.lo_z = 16'(z);
		r.it.radius = 15'(rad);
		r.known = known;
		r.want.visible = vis;
		r.want.nearest_distance = 32'(want_dist);
		return r;
	endfunction

	// unit box frustum of +-16 in x and y, forward of z = 0
	function automatic frustum_t setting_view(int s);
		frustum_t f;
		f = '0;
		if (s == SET_CUBE || s == SET_INVERTED) begin
			f.left      = plane(16384, 0, 0, 4096);
			f.right     = plane(-16384, 0, 0, 4096);
			f.top       = plane(0, -16384, 0, 4096);
			f.bottom    = plane(0, 16384, 0, 4096);
			f.far_plane = plane(0, 0, 16384, 0);
			f.region_lo = region(-4096, -4096, -4096);
			f.region_hi = region(4096, 4096, 16384);
			if (s == SET_INVERTED) begin
				f.region_lo = region(4096, 4096, 4096);
				f.region_hi = region(-4096, -4096, -4096);
			end
		end else if (s == SET_EXTREME) begin
			f.left      = {4{16'h8000}};
			f.right     = {4{16'h7fff}};
			f.top       = {16'h7fff, 16'h0000, 16'h7fff, 16'h8000};
			f.bottom    = '0;
			f.far_plane = {16'h8000, 16'h7fff, 16'h8000, 16'h8000};
			f.region_lo = {3{16'h8000}};
			f.region_hi = {3{16'h7fff}};
		end
		return f;
	endfunction

	// random frustum roughly around the origin so a fair share of volumes survive
	function automatic frustum_t shaped_view();
		frustum_t f;
		f.left      = plane(jitter(16384), jitter(16384), jitter(16384), $urandom_range(0, 12288));
		f.right     = plane(jitter(16384), jitter(16384), jitter(16384), $urandom_range(0, 12288));
		f.top       = plane(jitter(16384), jitter(16384), jitter(16384), $urandom_range(0, 12288));
		f.bottom    = plane(jitter(16384), jitter(16384), jitter(16384), $urandom_range(0, 12288));
		f.far_plane = plane(jitter(4096), jitter(4096), $urandom_range(8192, 16384),
			$urandom_range(0, 4096));
		f.region_lo = region(-int'($urandom_range(2048, 16384)), -int'($urandom_range(2048, 16384)),
			-int'($urandom_range(2048, 16384)));
		f.region_hi = region($urandom_range(2048, 16384), $urandom_range(2048, 16384),
			$urandom_range(2048, 16384));
		return f;
	endfunction

	function automatic frustum_t noise_view();
		frustum_t f;
		f.left      = {$urandom, $urandom};
		f.right     = {$urandom, $urandom};
		f.top       = {$urandom, $urandom};
		f.bottom    = {$urandom, $urandom};
		f.far_plane = {$urandom, $urandom};
		f.region_lo = 48'({$urandom, $urandom});
		f.region_hi = 48'({$urandom, $urandom});
		return f;
	endfunction

	function automatic frustum_t rim_view();
		frustum_t f;
		f.left      = {rim(), rim(), rim(), rim()};
		f.right     = {rim(), rim(), rim(), rim()};
		f.top       = {rim(), rim(), rim(), rim()};
		f.bottom    = {rim(), rim(), rim(), rim()};
		f.far_plane = {rim(), rim(), rim(), rim()};
		f.region_lo = {rim(), rim(), rim()};
		f.region_hi = {rim(), rim(), rim()};
		return f;
	endfunction

	// mostly small well-formed volumes with junk in the unused fields, some noise
	function automatic item_t random_item();
		item_t        it;
		logic [127:0] raw;
		int           pick;
		pick = $urandom_range(99);
		raw = {$urandom, $urandom, $urandom, $urandom};
		it = raw[$bits(item_t)-1:0];
		if (pick < 8)
			return it;
		it.kind = $urandom_range(1) ? KIND_SPHERE : KIND_BOX;
		it.lo_x = jitter(12288);
		it.lo_y = jitter(12288);
		it.lo_z = jitter(12288);
		if (it.kind == KIND_SPHERE) begin
			it.radius = 15'($urandom_range(0, 4096));
		end else begin
			it.hi_x = it.lo_x + 16'($urandom_range(0, 4096));
			it.hi_y = it.lo_y + 16'($urandom_range(0, 4096));
			it.hi_z = it.lo_z + 16'($urandom_range(0, 4096));
			if (pick < 14)
				it.hi_y = it.lo_y - 16'($urandom_range(1, 1024));
		end
		return it;
	endfunction

	// ---------------------------------------------------------------- drivers

	task automatic write_reg(cfg_idx_t idx, logic [PLANE_W-1:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		case (idx)
			CFG_PLANE_LEFT:   view.left = val;
			CFG_PLANE_RIGHT:  view.right = val;
			CFG_PLANE_TOP:    view.top = val;
			CFG_PLANE_BOTTOM: view.bottom = val;
			CFG_PLANE_FAR:    view.far_plane = val;
			CFG_REGION_LOW:   view.region_lo = val[REGION_W-1:0];
			CFG_REGION_HIGH:  view.region_hi = val[REGION_W-1:0];
			default: ;
		endcase
	endtask

	task automatic load_view(frustum_t f);
		write_reg(CFG_PLANE_LEFT, f.left);
		write_reg(CFG_PLANE_RIGHT, f.right);
		write_reg(CFG_PLANE_TOP, f.top);
		write_reg(CFG_PLANE_BOTTOM, f.bottom);
		write_reg(CFG_PLANE_FAR, f.far_plane);
		write_reg(CFG_REGION_LOW, {16'h0, f.region_lo});
		write_reg(CFG_REGION_HIGH, {16'h0, f.region_hi});
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic send_item(item_t it, bit known, result_t typed);
		@(negedge clk);
		while (!calm && $urandom_range(99) < 12) begin
			item_valid <= 1'b0;
			@(negedge clk);
		end
		item_valid <= 1'b1;
		item <= it;
		@(posedge clk);
		while (item_stall)
			@(posedge clk);
		awaited_culls.push_back(known ? typed : cull_predict(it));
	endtask

	// hold the sender off until every outstanding result is back
	task automatic settle();
		@(negedge clk);
		item_valid <= 1'b0;
		while (awaited_culls.size() != 0)
			@(posedge clk);
	endtask

	always @(negedge clk)
		result_stall <= !calm && ($urandom_range(99) < 12);

	// ---------------------------------------------------------------- checking

	always @(posedge clk) begin
		result_t want;
		if (arst_n && result_valid && !result_stall) begin
			if (awaited_culls.size() == 0) begin
				$error("result transfer with nothing outstanding: visible %0d, distance %0d",
					result.visible, $signed(result.nearest_distance));
				fails++;
			end else begin
				want = awaited_culls.pop_front();
				if (result.visible !== want.visible) begin
					$error("visible: expected %0d, got %0d", want.visible, result.visible);
					fails++;
				end
				if (result.nearest_distance !== want.nearest_distance) begin
					$error("nearest_distance: expected %0d, got %0d",
						$signed(want.nearest_distance), $signed(result.nearest_distance));
					fails++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("frustum_box_sphere_cull_tb: done, errors");
			$finish;
		end
	end

	// ---------------------------------------------------------------- sequence

	initial begin
		int cur;
		// reset frustum: every plane distance is zero and the region is the origin
		plan.push_back(box_row(SET_RESET, 0, 0, 0, 0, 0, 0, 1, 1, 0));
		plan.push_back(box_row(SET_RESET, -32768, -32768, -32768, 32767, 32767, 32767, 1, 1, 0));
		plan.push_back(box_row(SET_RESET, 256, 0, 0, 512, 0, 0, 1, 0, 0));
		plan.push_back(box_row(SET_RESET, 256, 256, 256, -256, -256, -256, 1, 0, 0));
		plan.push_back(box_row(SET_RESET, -32768, -32768, -32768, -32768, -32768, -32768,
			1, 0, 0));
		plan.push_back(ball_row(SET_RESET, 0, 0, 0, 0, 1, 1, 0));
		plan.push_back(ball_row(SET_RESET, 32767, -32768, 32767, 32767, 1, 1, -32767));
		plan.push_back(ball_row(SET_RESET, -32768, -32768, -32768, 1, 1, 1, -1));
		plan.push_back(box_row(SET_CUBE, -256, -256, 256, 256, 256, 512));
		// touching the left plane exactly, then one step outside
		plan.push_back(box_row(SET_CUBE, -5000, 0, 0, -4096, 0, 0));
		plan.push_back(box_row(SET_CUBE, -5000, 0, 0, -4097, 0, 0));
		plan.push_back(box_row(SET_CUBE, 0, 0, -512, 0, 0, -1));
		plan.push_back(box_row(SET_CUBE, 0, 0, -512, 0, 0, 0));
		plan.push_back(box_row(SET_CUBE, 0, 300, 0, 0, 200, 0));
		// sphere at exactly minus the radius, then just beyond
		plan.push_back(ball_row(SET_CUBE, -4352, 0, 0, 256));
		plan.push_back(ball_row(SET_CUBE, -4353, 0, 0, 256));
		plan.push_back(ball_row(SET_CUBE, 0, 0, -256, 256));
		plan.push_back(ball_row(SET_CUBE, 0, 0, -300, 256));
		plan.push_back(box_row(SET_INVERTED, -32768, -32768, -32768, 32767, 32767, 32767));
		plan.push_back(ball_row(SET_INVERTED, 0, 0, 256, 10));
		plan.push_back(box_row(SET_EXTREME, -32768, -32768, -32768, 32767, 32767, 32767));
		plan.push_back(box_row(SET_EXTREME, 32767, 32767, 32767, 32767, 32767, 32767));
		plan.push_back(ball_row(SET_EXTREME, -32768, -32768, -32768, 32767));
		plan.push_back(ball_row(SET_EXTREME, 32767, 32767, 32767, 0));

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		cur = SET_RESET;
		foreach (plan[i]) begin
			if (plan[i].setting != cur) begin
				settle();
				load_view(setting_view(plan[i].setting));
				cur = plan[i].setting;
			end
			send_item(plan[i].it, plan[i].known, plan[i].want);
		end

		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			settle();
			if (ph == 3)
				load_view(noise_view());
			else if (ph == 4)
				load_view(rim_view());
			else
				load_view(shaped_view());
			// one phase runs back to back on both sides
			calm = (ph == 1);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if (ph == 2 && n == PHASE_ITEMS / 2)
					settle();
				send_item(random_item(), 1'b0, '0);
			end
		end
		calm = 1'b0;
		settle();
		repeat (8) @(posedge clk);
		if (fails == 0)
			$display("frustum_box_sphere_cull_tb: done, clean");
		else
			$display("frustum_box_sphere_cull_tb: done, errors");
		$finish;
	end

endmodule
